// ===== hdl/mcs51_serial_port_model_top_macros.svh =====
// Assertion macros for the 8051 serial port model.
// Included by the top level; needs nothing else.
`ifndef MCS51_SERIAL_PORT_MODEL_TOP_MACROS_SVH
`define MCS51_SERIAL_PORT_MODEL_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("serial port assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("serial port assertion failed");

`endif

// ===== hdl/sps_pkg.sv =====
// Shared types and constants for the 8051 serial port model.
// No dependencies; imported by every module of the block.
`default_nettype none

package sps_pkg;

   // Operation codes of an input beat.
   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_SFR_READ  = 3'd1,
      OP_SFR_WRITE = 3'd2,
      OP_FRAME     = 3'd3,
      OP_BAUD      = 3'd4
   } op_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LINK_PRESENT = 2'd0;
   localparam logic [1:0] CSR_CLOCK_HZ     = 2'd1;
   localparam logic [1:0] CSR_SBUF_ADDRESS = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CLOCK_W     = 27;
   localparam int unsigned BAUD_W      = 23;

   // Serial modes from SCON bits 7:6.
   localparam logic [1:0] MODE_SHIFT_REG = 2'd0;
   localparam logic [1:0] MODE_FIXED_9   = 2'd2;

   // Register reset values.
   localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 27'd12000000;
   localparam logic [7:0]         SBUF_RESET     = 8'h99;

   // Division sizes: dividend is clock_hz times one or two, divisor at most 98304.
   localparam int unsigned DIVIDEND_W = CLOCK_W + 1;
   localparam int unsigned DIVISOR_W  = 17;
   localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam logic [DIVISOR_W-1:0] DIV_MODE0 = 17'd12;
   localparam logic [DIVISOR_W-1:0] DIV_MODE2 = 17'd64;
   localparam logic [BAUD_W-1:0]    BAUD_MAX  = 23'h7FFFFF;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // Result fields other than the baud rate.
   typedef struct packed {
      logic [7:0] read_byte;
      logic       rb8_write;
      logic       rb8_value;
      logic       ti_set;
      logic       ri_set;
      logic       irq_request;
      logic       irq_high;
      logic       frame_accepted;
      logic       tx_valid;
      logic [8:0] tx_frame;
   } result_type;

   // One queued job: a finished result, or a division still to be done.
   typedef struct packed {
      result_type               res;
      logic                     is_div;
      logic [DIVIDEND_W-1:0]    dividend;
      logic [DIVISOR_W-1:0]     divisor;
   } entry_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== hdl/mcs51_serial_port_model_top.sv =====
// Top level of the 8051 serial port model: front end, job queue, back end.
// Depends on sps_pkg, sps_front, sps_queue, sps_back and the macros header.
//
//   Channel  Direction  Handshake               Content
//   req_     in         req_valid / req_ready   one serial port operation
//   rsp_     out        rsp_valid / rsp_ready   one result per operation
//   csr_     in         csr_write               link_present, clock_hz, sbuf_address
//
// Tick, SFR read, SFR write, frame arrival and undefined operations are classified as
// they are accepted, pass through the queue and the result register, and appear on rsp_
// once the back end is idle and rsp_ is free. A baud query runs through the bit-serial
// divider, which takes no further job until its result is loaded. Reset is synchronous
// and resets the port state, configuration, queue and sequencer. A stalled rsp_ keeps
// the result in its register; the queue takes beats until full, then req_ready drops.
`default_nettype none
`include "mcs51_serial_port_model_top_macros.svh"

module mcs51_serial_port_model_top #(
   parameter int unsigned QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [2:0]                      req_opcode,
   input  wire logic [7:0]                      req_sfr_address,
   input  wire logic [8:0]                      req_data_word,
   input  wire logic [7:0]                      req_scon_value,
   input  wire logic                            req_global_enable,
   input  wire logic                            req_serial_enable,
   input  wire logic                            req_high_priority,
   input  wire logic [1:0]                      req_nest_level,
   input  wire logic                            req_double_rate,
   input  wire logic [7:0]                      req_reload_value,
   input  wire logic                            req_link_ok,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_read_byte,
   output logic                                 rsp_rb8_write,
   output logic                                 rsp_rb8_value,
   output logic                                 rsp_ti_set,
   output logic                                 rsp_ri_set,
   output logic                                 rsp_irq_request,
   output logic                                 rsp_irq_high,
   output logic                                 rsp_frame_accepted,
   output logic                                 rsp_tx_valid,
   output logic [8:0]                           rsp_tx_frame,
   output logic [sps_pkg::BAUD_W-1:0]           rsp_baud_rate,
   input  wire logic                            csr_write,
   input  wire logic [sps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sps_pkg::CLOCK_W-1:0]     csr_data
);
   import sps_pkg::*;

   queue_status_type q_status;
   entry_type        push_entry, head;
   logic             push, pop;
   result_type       rsp_res;

   sps_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_sfr_address   (req_sfr_address),
      .req_data_word     (req_data_word),
      .req_scon_value    (req_scon_value),
      .req_global_enable (req_global_enable),
      .req_serial_enable (req_serial_enable),
      .req_high_priority (req_high_priority),
      .req_nest_level    (req_nest_level),
      .req_double_rate   (req_double_rate),
      .req_reload_value  (req_reload_value),
      .req_link_ok       (req_link_ok),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   sps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   sps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res),
      .rsp_baud  (rsp_baud_rate)
   );

   // Unpack the result beat onto its ports.
   assign rsp_read_byte      = rsp_res.read_byte;
   assign rsp_rb8_write      = rsp_res.rb8_write;
   assign rsp_rb8_value      = rsp_res.rb8_value;
   assign rsp_ti_set         = rsp_res.ti_set;
   assign rsp_ri_set         = rsp_res.ri_set;
   assign rsp_irq_request    = rsp_res.irq_request;
   assign rsp_irq_high       = rsp_res.irq_high;
   assign rsp_frame_accepted = rsp_res.frame_accepted;
   assign rsp_tx_valid       = rsp_res.tx_valid;
   assign rsp_tx_frame       = rsp_res.tx_frame;

   // A non-baud beat that sends a frame, writes RB8 or sets TI carries no baud rate.
   `SPS_ASSERT_IMPL(a_baud_alone, clock, reset,
      rsp_valid && (rsp_tx_valid || rsp_rb8_write || rsp_ti_set), rsp_baud_rate == '0)
   // A high-priority flag only comes with a request.
   `SPS_ASSERT_IMPL(a_irq_high, clock, reset, rsp_valid && rsp_irq_high, rsp_irq_request)
   // An accepted frame also sets RI and writes RB8.
   `SPS_ASSERT_IMPL(a_frame_flags, clock, reset,
      rsp_valid && rsp_frame_accepted, rsp_ri_set && rsp_rb8_write)
   // The queue is never popped while empty.
   `SPS_ASSERT_IMPL(a_pop_nonempty, clock, reset, pop, q_status.not_empty)

endmodule

`default_nettype wire

// ===== hdl/sps_front.sv =====
// Front end: accepts input beats, holds the port state and configuration,
// and turns each beat into a queue entry. Depends on sps_pkg.
`default_nettype none

module sps_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [2:0]                      req_opcode,
   input  wire logic [7:0]                      req_sfr_address,
   input  wire logic [8:0]                      req_data_word,
   input  wire logic [7:0]                      req_scon_value,
   input  wire logic                            req_global_enable,
   input  wire logic                            req_serial_enable,
   input  wire logic                            req_high_priority,
   input  wire logic [1:0]                      req_nest_level,
   input  wire logic                            req_double_rate,
   input  wire logic [7:0]                      req_reload_value,
   input  wire logic                            req_link_ok,
   input  wire logic                            csr_write,
   input  wire logic [sps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sps_pkg::CLOCK_W-1:0]     csr_data,
   input  wire sps_pkg::queue_status_type       q_status,
   output logic                                 push,
   output sps_pkg::entry_type                   push_entry
);
   import sps_pkg::*;

   logic               link_present_ff;
   logic [CLOCK_W-1:0] clock_hz_ff;
   logic [7:0]         sbuf_address_ff;
   logic [8:0]         rx_word_ff, rx_word_in;
   logic [8:0]         tx_word_ff, tx_word_in;

   logic       ri, ti, tb8, ren, sm2;
   logic [1:0] mode;
   logic       sbuf_hit;
   logic [8:0] reload_span;
   logic [12:0] reload_ticks;

   assign ri   = req_scon_value[0];
   assign ti   = req_scon_value[1];
   assign tb8  = req_scon_value[3];
   assign ren  = req_scon_value[4];
   assign sm2  = req_scon_value[5];
   assign mode = req_scon_value[7:6];

   assign sbuf_hit  = (req_sfr_address == sbuf_address_ff);
   assign req_ready = q_status.not_full;
   assign push      = req_valid && req_ready;

   // Timer 1 period in oscillator cycles: (256 - TH1) * 12.
   assign reload_span  = 9'd256 - {1'b0, req_reload_value};
   assign reload_ticks = 13'({4'd0, reload_span} * 13'd12);

   // Classify the beat and build its result or division job.
   always_comb begin
      push_entry = '0;
      rx_word_in = rx_word_ff;
      tx_word_in = tx_word_ff;
      case (op_type'(req_opcode))
         OP_TICK: begin
            push_entry.res.rb8_write = 1'b1;
            push_entry.res.rb8_value = rx_word_ff[8];
            if (req_global_enable && req_serial_enable && (ri || ti)) begin
               if (req_high_priority) begin
                  if (req_nest_level < 2'd2) begin
                     push_entry.res.irq_request = 1'b1;
                     push_entry.res.irq_high    = 1'b1;
                  end
               end else if (req_nest_level == 2'd0) begin
                  push_entry.res.irq_request = 1'b1;
               end
            end
         end
         OP_SFR_READ: begin
            if (sbuf_hit) begin
               push_entry.res.read_byte = rx_word_ff[7:0];
            end
         end
         OP_SFR_WRITE: begin
            if (sbuf_hit) begin
               if (!link_present_ff) begin
                  push_entry.res.ti_set = 1'b1;
               end else begin
                  tx_word_in                = {tb8, req_data_word[7:0]};
                  push_entry.res.tx_valid   = 1'b1;
                  push_entry.res.tx_frame   = tx_word_in;
                  push_entry.res.ti_set     = req_link_ok;
               end
            end
         end
         OP_FRAME: begin
            if (ren && !ri) begin
               push_entry.res.rb8_write = 1'b1;
               push_entry.res.rb8_value = req_data_word[8];
               rx_word_in               = req_data_word;
               if (!(sm2 && !req_data_word[8])) begin
                  push_entry.res.ri_set         = 1'b1;
                  push_entry.res.frame_accepted = 1'b1;
               end
            end
         end
         OP_BAUD: begin
            push_entry.is_div = 1'b1;
            if (req_double_rate && (mode != MODE_SHIFT_REG)) begin
               push_entry.dividend = {clock_hz_ff, 1'b0};
            end else begin
               push_entry.dividend = {1'b0, clock_hz_ff};
            end
            if (mode == MODE_SHIFT_REG) begin
               push_entry.divisor = DIV_MODE0;
            end else if (mode == MODE_FIXED_9) begin
               push_entry.divisor = DIV_MODE2;
            end else begin
               push_entry.divisor = {reload_ticks, 4'd0} << 1;
            end
         end
         default: begin
            push_entry = '0;
         end
      endcase
   end

   // Port state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_present_ff <= 1'b0;
         clock_hz_ff     <= CLOCK_HZ_RESET;
         sbuf_address_ff <= SBUF_RESET;
         rx_word_ff      <= '0;
         tx_word_ff      <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LINK_PRESENT: link_present_ff <= csr_data[0];
               CSR_CLOCK_HZ:     clock_hz_ff     <= csr_data;
               CSR_SBUF_ADDRESS: sbuf_address_ff <= csr_data[7:0];
               default:          ;
            endcase
         end
         if (push) begin
            rx_word_ff <= rx_word_in;
            tx_word_ff <= tx_word_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sps_queue.sv =====
// Short queue of jobs between the front end and the back end.
// Depends on sps_pkg for the entry and status types.
`default_nettype none

module sps_queue #(
   parameter int unsigned DEPTH = sps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire sps_pkg::entry_type        push_entry,
   input  wire logic                      pop,
   output sps_pkg::entry_type             head,
   output sps_pkg::queue_status_type      q_status
);
   import sps_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign head              = slot_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.not_full  = (count_ff != FULL_CNT);

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill count; both sides may move in the same cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sps_back.sv =====
// Back end: takes jobs from the queue, runs the baud rate division one
// quotient bit per cycle, and holds the result beat. Depends on sps_pkg.
`default_nettype none

module sps_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sps_pkg::entry_type            head,
   input  wire sps_pkg::queue_status_type     q_status,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output sps_pkg::result_type                rsp_res,
   output logic [sps_pkg::BAUD_W-1:0]         rsp_baud
);
   import sps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

   state_type             state_ff;
   logic                  rsp_valid_ff;
   result_type            res_ff;
   logic [BAUD_W-1:0]     baud_ff;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIV_CNT_W-1:0]  step_ff;

   logic                  out_free;
   logic                  load_out;
   logic [DIVISOR_W:0]    shifted, diff;
   logic                  fits;
   logic [BAUD_W-1:0]     baud_sat;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && q_status.not_empty && (head.is_div || out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = res_ff;
   assign rsp_baud  = baud_ff;

   // A new result beat is loaded from a finished job or from the divider.
   assign load_out = ((state_ff == ST_IDLE) && pop && !head.is_div) ||
                     ((state_ff == ST_DONE) && out_free);

   // One restoring division step.
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = (shifted >= {1'b0, div_ff});
   assign rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
   assign quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};

   // Saturate the quotient to the baud field.
   assign baud_sat = (quo_ff > DIVIDEND_W'(BAUD_MAX)) ? BAUD_MAX : quo_ff[BAUD_W-1:0];

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (head.is_div) begin
                     quo_ff   <= head.dividend;
                     rem_ff   <= '0;
                     div_ff   <= head.divisor;
                     step_ff  <= '0;
                     state_ff <= ST_DIV;
                  end else begin
                     res_ff  <= head.res;
                     baud_ff <= '0;
                  end
               end
            end
            ST_DIV: begin
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  res_ff   <= '0;
                  baud_ff  <= baud_sat;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
